### rtl/rsv_pkg.sv
// ----------------------------------------------------------------------------
// rsv_pkg
// Shared widths, register indexes and controller/datapath interface types
// for the RSA sign/verify modular exponentiation block.
// ----------------------------------------------------------------------------
package rsv_pkg;

  localparam int WIDTH = 32;
  localparam int CNT_W = $clog2(WIDTH);
  localparam int IDX_W = 2;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_MODULUS  = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_PRIV_EXP = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_PUB_EXP  = IDX_W'(2);

  // which product the multiplier is forming
  typedef enum logic [1:0] {
    SEL_RED = 2'b00,
    SEL_ACC = 2'b01,
    SEL_SQ  = 2'b10
  } mul_sel_t;

  typedef struct packed {
    logic     load;
    logic     mul_start;
    mul_sel_t sel;
    logic     mul_step;
    logic     shift_ex;
    logic     load_out;
  } rsv_cmd_t;

  typedef struct packed {
    logic mul_last;
    logic ex_zero;
    logic ex_lsb;
    logic ex_hi_zero;
  } rsv_sts_t;

endpackage

### rtl/rsa_sign_verify_modexp.sv
// ----------------------------------------------------------------------------
// rsa_sign_verify_modexp
// Textbook RSA sign/verify by right-to-left square-and-multiply modexp.
// ----------------------------------------------------------------------------
// Usage:
//   cfg channel writes modulus (index 0), private exponent (1) and public
//   exponent (2); cfg_ready is always high. Write only while idle.
//   in channel: in_func 0 signs in_message with the private exponent,
//   in_func 1 raises in_signature to the public exponent and sets
//   out_verified when the result equals in_message as given.
//   One item is worked on at a time; in_stall is high from acceptance until
//   the result moves into the output register.
//   Each modular product is formed in the bit-serial shift-add multiplier;
//   one product per set exponent bit plus one square per further bit, after
//   a base reduction.
//   Next item: it can be taken in the cycle after the result is loaded.
//   The result waits in the output register while out_stall is high; the
//   next item may be accepted meanwhile and finishes once it drains.
//   Reset: modulus 2, both exponents 0, no result pending.
// ----------------------------------------------------------------------------
module rsa_sign_verify_modexp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_func,
  input  logic [rsv_pkg::WIDTH-1:0]     in_message,
  input  logic [rsv_pkg::WIDTH-1:0]     in_signature,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [rsv_pkg::WIDTH-1:0]     out_value,
  output logic                          out_verified,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rsv_pkg::IDX_W-1:0]     cfg_index,
  input  logic [rsv_pkg::WIDTH-1:0]     cfg_data
);

  rsv_pkg::rsv_cmd_t cmd;
  rsv_pkg::rsv_sts_t sts;

  assign cfg_ready = 1'b1;

  rsv_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  rsv_datapath u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_idx      (cfg_index),
    .cfg_wdata    (cfg_data),
    .in_func      (in_func),
    .in_message   (in_message),
    .in_signature (in_signature),
    .cmd          (cmd),
    .sts          (sts),
    .out_value    (out_value),
    .out_verified (out_verified)
  );

endmodule

### rtl/rsv_datapath.sv
// ----------------------------------------------------------------------------
// rsv_datapath
// Key registers, exponent shifter, accumulator/base registers and a
// one-bit-per-cycle shift-add modular multiplier.
// ----------------------------------------------------------------------------
module rsv_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [rsv_pkg::IDX_W-1:0]     cfg_idx,
  input  logic [rsv_pkg::WIDTH-1:0]     cfg_wdata,
  input  logic                          in_func,
  input  logic [rsv_pkg::WIDTH-1:0]     in_message,
  input  logic [rsv_pkg::WIDTH-1:0]     in_signature,
  input  rsv_pkg::rsv_cmd_t             cmd,
  output rsv_pkg::rsv_sts_t             sts,
  output logic [rsv_pkg::WIDTH-1:0]     out_value,
  output logic                          out_verified
);

  localparam int W = rsv_pkg::WIDTH;

  logic [W-1:0] modulus_r;
  logic [W-1:0] priv_exp_r;
  logic [W-1:0] pub_exp_r;

  logic                      func_r;
  logic [W-1:0]              msg_r;
  logic [W-1:0]              mod_r;
  logic [W-1:0]              ex_r;
  logic [W-1:0]              acc_r;
  logic [W-1:0]              base_r;
  logic [W-1:0]              opa_r;
  logic [W-1:0]              opb_r;
  logic [W-1:0]              prod_r;
  logic [rsv_pkg::CNT_W-1:0] cnt_r;
  rsv_pkg::mul_sel_t         sel_r;
  logic [W-1:0]              value_r;
  logic                      verified_r;

  logic [W-1:0] prod_nxt;
  logic         mul_last;

  // r = (2r + b*a) mod m, a < m; m of zero wraps at 2^W
  function automatic logic [W-1:0] mm_step(input logic [W-1:0] r, input logic [W-1:0] a,
                                           input logic b, input logic [W-1:0] m);
    logic         mz;
    logic [W:0]   d;
    logic [W-1:0] d2;
    logic [W:0]   s;
    mz = (m == '0);
    d  = {r, 1'b0};
    if (!mz && (d >= {1'b0, m})) begin
      d = d - {1'b0, m};
    end
    d2 = d[W-1:0];
    s  = {1'b0, d2} + (b ? {1'b0, a} : '0);
    if (!mz && (s >= {1'b0, m})) begin
      s = s - {1'b0, m};
    end
    return s[W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r  <= W'(2);
      priv_exp_r <= '0;
      pub_exp_r  <= '0;
    end else if (cfg_we) begin
      if (cfg_idx == rsv_pkg::REG_MODULUS) begin
        modulus_r <= cfg_wdata;
      end
      if (cfg_idx == rsv_pkg::REG_PRIV_EXP) begin
        priv_exp_r <= cfg_wdata;
      end
      if (cfg_idx == rsv_pkg::REG_PUB_EXP) begin
        pub_exp_r <= cfg_wdata;
      end
    end
  end

  assign prod_nxt = mm_step(prod_r, opa_r, opb_r[W-1], mod_r);
  assign mul_last = (cnt_r == rsv_pkg::CNT_W'(W-1));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_func;
      msg_r  <= in_message;
      mod_r  <= modulus_r;
      ex_r   <= in_func ? pub_exp_r : priv_exp_r;
      acc_r  <= W'(1);
      // base reduction is base * (1 mod m)
      opa_r  <= (modulus_r == W'(1)) ? '0 : W'(1);
      opb_r  <= in_func ? in_signature : in_message;
      prod_r <= '0;
      cnt_r  <= '0;
      sel_r  <= rsv_pkg::SEL_RED;
    end else if (cmd.mul_start) begin
      opa_r  <= base_r;
      opb_r  <= (cmd.sel == rsv_pkg::SEL_ACC) ? acc_r : base_r;
      prod_r <= '0;
      cnt_r  <= '0;
      sel_r  <= cmd.sel;
    end else if (cmd.mul_step) begin
      prod_r <= prod_nxt;
      opb_r  <= {opb_r[W-2:0], 1'b0};
      cnt_r  <= cnt_r + rsv_pkg::CNT_W'(1);
      if (mul_last) begin
        case (sel_r)
          rsv_pkg::SEL_ACC: begin
            acc_r <= prod_nxt;
          end
          default: begin
            base_r <= prod_nxt;
          end
        endcase
      end
    end
    if (cmd.shift_ex) begin
      ex_r <= {1'b0, ex_r[W-1:1]};
    end
    if (cmd.load_out) begin
      value_r    <= acc_r;
      verified_r <= func_r && (acc_r == msg_r);
    end
  end

  assign sts.mul_last   = mul_last;
  assign sts.ex_zero    = (ex_r == '0);
  assign sts.ex_lsb     = ex_r[0];
  assign sts.ex_hi_zero = (ex_r[W-1:1] == '0);

  assign out_value    = value_r;
  assign out_verified = verified_r;

endmodule

### rtl/rsv_ctrl.sv
// ----------------------------------------------------------------------------
// rsv_ctrl
// Sequencer for right-to-left square-and-multiply: base reduction, one
// multiply per set exponent bit, one square per further bit, result hand-off.
// ----------------------------------------------------------------------------
module rsv_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  rsv_pkg::rsv_sts_t sts,
  output rsv_pkg::rsv_cmd_t cmd
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_RED  = 7'b0000010,
    S_BIT  = 7'b0000100,
    S_ACC  = 7'b0001000,
    S_NEXT = 7'b0010000,
    S_SQ   = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_RED;
        end
      end
      S_RED: begin
        cmd.mul_step = 1'b1;
        if (sts.mul_last) begin
          state_nxt = S_BIT;
        end
      end
      S_BIT: begin
        if (sts.ex_zero) begin
          state_nxt = S_OUT;
        end else if (sts.ex_lsb) begin
          cmd.mul_start = 1'b1;
          cmd.sel       = rsv_pkg::SEL_ACC;
          state_nxt     = S_ACC;
        end else begin
          state_nxt = S_NEXT;
        end
      end
      S_ACC: begin
        cmd.mul_step = 1'b1;
        if (sts.mul_last) begin
          state_nxt = S_NEXT;
        end
      end
      S_NEXT: begin
        cmd.shift_ex = 1'b1;
        // no square once the remaining exponent is used up
        if (sts.ex_hi_zero) begin
          state_nxt = S_BIT;
        end else begin
          cmd.mul_start = 1'b1;
          cmd.sel       = rsv_pkg::SEL_SQ;
          state_nxt     = S_SQ;
        end
      end
      S_SQ: begin
        cmd.mul_step = 1'b1;
        if (sts.mul_last) begin
          state_nxt = S_BIT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = cmd.load_out ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

`ifndef ASSERT_OFF
  a_onehot_state: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("controller state not one-hot");

  a_load_to_reduce: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && in_valid) |=> (state_r == S_RED))
    else $error("accepted item did not start base reduction");

  a_acc_then_shift: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ACC && sts.mul_last) |=> (state_r == S_NEXT))
    else $error("multiply did not advance the exponent");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || !out_stall))
    else $error("result register overwritten while held");
`endif

endmodule
